// ===== design/refractive_index_dispersion_eval_core_defines.svh =====
// Assertion macros for the verification files of the dispersion core; ride_checker uses them.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef REFRACTIVE_INDEX_DISPERSION_EVAL_CORE_DEFINES_SVH
`define REFRACTIVE_INDEX_DISPERSION_EVAL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RIDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ride_pkg.sv =====
// Shared types and constants for the refractive index dispersion core.
// No dependencies; imported by every module of the block.
package ride_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_SQUARE,
    S_CB_GO, S_CB_WAIT, S_CC_GO, S_CC_WAIT, S_CT_GO, S_CT_WAIT, S_CA_SUM, S_CA_CHECK,
    S_SM_INIT, S_SM_READ, S_SM_TERM, S_SM_TOL, S_SM_POLE, S_SM_MUL2, S_SM_PROD,
    S_SM_GO, S_SM_WAIT, S_SM_ACC, S_SM_CHECK, S_SQ_WAIT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_WL  = 3'd1,
    ST_DOMAIN   = 3'd2,
    ST_POLE     = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_NONPOS   = 3'd5
  } status_t;

  localparam logic [2:0] REG_MODEL_KIND = 3'd0;
  localparam logic [2:0] REG_INDEX_A    = 3'd1;
  localparam logic [2:0] REG_CAUCHY_B   = 3'd2;
  localparam logic [2:0] REG_CAUCHY_C   = 3'd3;
  localparam logic [2:0] REG_DOMAIN_MIN = 3'd4;
  localparam logic [2:0] REG_DOMAIN_MAX = 3'd5;
  localparam logic [2:0] REG_TERM_COUNT = 3'd6;

  localparam logic [1:0] KIND_CAUCHY    = 2'd1;
  localparam logic [1:0] KIND_SELLMEIER = 2'd2;

  localparam logic ACT_WRITE = 1'b0;

  localparam logic [63:0] TERM_LIMIT = 64'h0200_0000_0000_0000;
  localparam logic [63:0] ONE_Q28    = 64'h0000_0000_1000_0000;
  localparam logic [63:0] SUM_LIMIT  = 64'h0000_0010_0000_0000;
  localparam logic [63:0] INDEX_MAX  = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic        start;
    logic [63:0] num_hi;
    logic [63:0] num_lo;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        ok;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

// ===== design/ride_divider.sv =====
// Restoring divider of a 128-bit dividend by a 64-bit divisor, one bit per cycle.
// Depends on ride_pkg for the request and response structs.
module ride_divider (
  input  logic               clk,
  input  logic               rst,
  input  ride_pkg::div_req_t req,
  output ride_pkg::div_rsp_t rsp
);
  import ride_pkg::*;

  localparam logic [6:0] DIV_STEPS = 7'd64;

  logic        busy;
  logic        done;
  logic        ok;
  logic [6:0]  count;
  logic [64:0] rem;
  logic [63:0] num;
  logic [63:0] den;
  logic [63:0] quo;
  logic [64:0] shifted;
  logic        take;

  assign shifted = {rem[63:0], num[63]};
  assign take    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if ((req.den == 64'd0) || (req.num_hi >= req.den)) begin
          done <= 1'b1;
          ok   <= 1'b0;
        end else begin
          busy  <= 1'b1;
          count <= DIV_STEPS;
          rem   <= {1'b0, req.num_hi};
          num   <= req.num_lo;
          den   <= req.den;
        end
      end else if (busy) begin
        rem   <= take ? (shifted - {1'b0, den}) : shifted;
        num   <= {num[62:0], 1'b0};
        quo   <= {quo[62:0], take};
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          ok   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ok   = ok;
  assign rsp.quo  = quo;
endmodule

// ===== design/ride_sqrt.sv =====
// Integer square root of a 64-bit radicand, two radicand bits per cycle.
// Depends on ride_pkg for the request and response structs.
module ride_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  ride_pkg::sqrt_req_t req,
  output ride_pkg::sqrt_rsp_t rsp
);
  import ride_pkg::*;

  localparam logic [5:0] SQRT_STEPS = 6'd32;

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= SQRT_STEPS;
        rem   <= req.radicand;
        res   <= 64'd0;
        bitv  <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv  <= bitv >> 2;
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[31:0];
endmodule

// ===== design/refractive_index_dispersion_eval_core.sv =====
// Top level of the dispersion core: configuration, term table, sequencer, datapath.
// Depends on ride_pkg, ride_divider and ride_sqrt.
//
//   channel | signals                                    | direction
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data     | write port
//   in      | in_valid in_ready action term_slot ...     | request
//   out     | out_valid out_ready refractive_index status| result
//
// Cauchy evaluation makes three passes through the 64-step divider. Sellmeier makes
// one divider pass per term, then, for a sum in range, one pass through the square
// root unit. A term write or a constant evaluation uses neither unit.
// Reset is synchronous; the term table is not cleared. in_ready is high only
// when the sequencer is idle; a result held by out_ready stalls the next finish.
module refractive_index_dispersion_eval_core #(
  parameter int MAX_TERMS  = 32,
  parameter int POLE_GUARD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  term_slot,
  input  logic signed [31:0] term_strength,
  input  logic [39:0] term_resonance,
  input  logic [31:0] wavelength,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] refractive_index,
  output logic [2:0]  status
);
  import ride_pkg::*;

  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PG_W  = $clog2(POLE_GUARD + 2);
  localparam int TOL_W = 64 + PG_W;

  logic [1:0]  model_kind;
  logic [31:0] index_a;
  logic [31:0] cauchy_b;
  logic [31:0] cauchy_c;
  logic [31:0] domain_min;
  logic [31:0] domain_max;
  logic [5:0]  term_count;

  logic [31:0] strength_mem [MAX_TERMS];
  logic [39:0] resonance_mem[MAX_TERMS];
  logic [31:0] rd_strength;
  logic [39:0] rd_resonance;

  state_t      state, state_next;
  logic [31:0] w;
  logic [63:0] w2;
  logic signed [63:0] acc;
  logic signed [63:0] tb;
  logic signed [63:0] tc;
  logic [56:0] tmag;
  logic [63:0] den_r;
  logic [63:0] scale_r;
  logic [63:0] tol_r;
  logic [31:0] bmag;
  logic        neg_term;
  logic [63:0] p_lo;
  logic [63:0] p_hi;
  logic [63:0] prod_hi;
  logic [63:0] prod_lo;
  logic [63:0] term_q;
  logic [6:0]  k;
  logic [6:0]  n_terms;
  status_t     st_r;
  logic [31:0] idx_r;

  logic        fin_set;
  status_t     fin_status;
  logic [31:0] fin_index;
  logic [56:0] div_mag;
  logic        accept;
  logic        out_free;
  logic [6:0]  slot_ext;
  logic [63:0] c_al;
  logic        below;
  logic [TOL_W-1:0] tol_prod;
  logic        div_fail;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign slot_ext  = {2'b00, term_slot};
  assign n_terms   = ({1'b0, term_count} > 7'(MAX_TERMS)) ? 7'(MAX_TERMS)
                                                         : {1'b0, term_count};
  assign c_al      = {rd_resonance, 24'd0};
  assign below     = w2 < c_al;
  assign tol_prod  = TOL_W'(scale_r) * TOL_W'(POLE_GUARD);
  assign div_fail  = !div_rsp.ok || (div_rsp.quo >= TERM_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      model_kind <= 2'd0;
      index_a    <= 32'd268435456;
      cauchy_b   <= 32'd0;
      cauchy_c   <= 32'd0;
      domain_min <= 32'd1;
      domain_max <= 32'hFFFF_FFFF;
      term_count <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODEL_KIND: model_kind <= cfg_data[1:0];
        REG_INDEX_A:    index_a    <= cfg_data;
        REG_CAUCHY_B:   cauchy_b   <= cfg_data;
        REG_CAUCHY_C:   cauchy_c   <= cfg_data;
        REG_DOMAIN_MIN: domain_min <= cfg_data;
        REG_DOMAIN_MAX: domain_max <= cfg_data;
        REG_TERM_COUNT: term_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (action == ACT_WRITE) && (slot_ext < 7'(MAX_TERMS))) begin
      strength_mem[slot_ext[AW-1:0]]  <= term_strength;
      resonance_mem[slot_ext[AW-1:0]] <= term_resonance;
    end
    rd_strength  <= strength_mem[k[AW-1:0]];
    rd_resonance <= resonance_mem[k[AW-1:0]];
  end

  always_comb begin
    case (state)
      S_CB_GO: div_mag = {25'd0, mag32(cauchy_b)};
      S_CC_GO: div_mag = {25'd0, mag32(cauchy_c)};
      default: div_mag = tmag;
    endcase
    div_req.start  = (state == S_CB_GO) || (state == S_CC_GO) || (state == S_CT_GO) ||
                     (state == S_SM_GO);
    div_req.num_hi = (state == S_SM_GO) ? prod_hi : {19'd0, div_mag[56:12]};
    div_req.num_lo = (state == S_SM_GO) ? prod_lo : {div_mag[11:0], 52'd0};
    div_req.den    = (state == S_SM_GO) ? den_r : w2;
    sqrt_req.start    = (state == S_SM_CHECK) && (acc > 64'sd0) &&
                        ($unsigned(acc) < SUM_LIMIT);
    sqrt_req.radicand = {acc[35:0], 28'd0};
  end

  ride_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ride_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_set    = 1'b0;
    fin_status = ST_OK;
    fin_index  = 32'd0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_WRITE) begin
            fin_set    = 1'b1;
            state_next = S_FINISH;
          end else begin
            state_next = S_SQUARE;
          end
        end
      end
      S_SQUARE: begin
        if (w == 32'd0) begin
          fin_set = 1'b1; fin_status = ST_ZERO_WL; state_next = S_FINISH;
        end else if ((w < domain_min) || (w > domain_max)) begin
          fin_set = 1'b1; fin_status = ST_DOMAIN; state_next = S_FINISH;
        end else if (model_kind == KIND_CAUCHY) begin
          state_next = S_CB_GO;
        end else if (model_kind == KIND_SELLMEIER) begin
          state_next = S_SM_INIT;
        end else begin
          fin_set    = 1'b1;
          fin_status = ($signed(index_a) <= 32'sd0) ? ST_NONPOS : ST_OK;
          fin_index  = index_a;
          state_next = S_FINISH;
        end
      end
      S_CB_GO: state_next = S_CB_WAIT;
      S_CC_GO: state_next = S_CC_WAIT;
      S_CT_GO: state_next = S_CT_WAIT;
      S_CB_WAIT, S_CC_WAIT, S_CT_WAIT, S_SM_WAIT: begin
        if (div_rsp.done) begin
          if (div_fail) begin
            fin_set = 1'b1; fin_status = ST_OVERFLOW; state_next = S_FINISH;
          end else if (state == S_CB_WAIT) begin
            state_next = S_CC_GO;
          end else if (state == S_CC_WAIT) begin
            state_next = S_CT_GO;
          end else if (state == S_CT_WAIT) begin
            state_next = S_CA_SUM;
          end else begin
            state_next = S_SM_ACC;
          end
        end
      end
      S_CA_SUM: state_next = S_CA_CHECK;
      S_CA_CHECK: begin
        fin_set    = 1'b1;
        state_next = S_FINISH;
        if (acc <= 64'sd0) begin
          fin_status = ST_NONPOS;
        end else if ($unsigned(acc) > INDEX_MAX) begin
          fin_status = ST_OVERFLOW;
        end else begin
          fin_index = acc[31:0];
        end
      end
      S_SM_INIT: state_next = S_SM_READ;
      S_SM_READ: state_next = (k == n_terms) ? S_SM_CHECK : S_SM_TERM;
      S_SM_TERM: state_next = S_SM_TOL;
      S_SM_TOL:  state_next = S_SM_POLE;
      S_SM_POLE: begin
        if (den_r <= tol_r) begin
          fin_set = 1'b1; fin_status = ST_POLE; state_next = S_FINISH;
        end else begin
          state_next = S_SM_MUL2;
        end
      end
      S_SM_MUL2: state_next = S_SM_PROD;
      S_SM_PROD: state_next = S_SM_GO;
      S_SM_GO:   state_next = S_SM_WAIT;
      S_SM_ACC:  state_next = S_SM_READ;
      S_SM_CHECK: begin
        if (acc <= 64'sd0) begin
          fin_set = 1'b1; fin_status = ST_NONPOS; state_next = S_FINISH;
        end else if ($unsigned(acc) >= SUM_LIMIT) begin
          fin_set = 1'b1; fin_status = ST_OVERFLOW; state_next = S_FINISH;
        end else begin
          state_next = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (sqrt_rsp.done) begin
          fin_set    = 1'b1;
          fin_index  = sqrt_rsp.root;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_set) begin
      st_r  <= fin_status;
      idx_r <= fin_index;
    end
    case (state)
      S_IDLE:   w  <= wavelength;
      S_SQUARE: w2 <= 64'(w) * 64'(w);
      S_CB_WAIT: tb <= cauchy_b[31] ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
      S_CC_WAIT: tmag <= div_rsp.quo[56:0];
      S_CT_WAIT: tc <= cauchy_c[31] ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
      S_CA_SUM: acc <= 64'($signed(index_a)) + tb + tc;
      S_SM_INIT: begin
        acc <= $signed(ONE_Q28);
        k   <= 7'd0;
      end
      S_SM_TERM: begin
        den_r    <= below ? (c_al - w2) : (w2 - c_al);
        scale_r  <= below ? c_al : w2;
        bmag     <= mag32(rd_strength);
        neg_term <= rd_strength[31] != below;
      end
      S_SM_TOL:  tol_r <= 64'(tol_prod >> 52);
      S_SM_POLE: p_lo  <= 64'(bmag) * 64'(w2[31:0]);
      S_SM_MUL2: p_hi  <= 64'(bmag) * 64'(w2[63:32]);
      S_SM_PROD: {prod_hi, prod_lo} <= {64'd0, p_lo} + {32'd0, p_hi, 32'd0};
      S_SM_WAIT: term_q <= div_rsp.quo;
      S_SM_ACC: begin
        acc <= neg_term ? (acc - $signed(term_q)) : (acc + $signed(term_q));
        k   <= k + 7'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      refractive_index <= (st_r == ST_OK) ? idx_r : 32'd0;
      status           <= st_r;
    end
  end
endmodule

// ===== design/ride_checker.sv =====
// Port-level checks on the dispersion core, attached to it by a bind statement.
// Depends on ride_pkg and the assertion macros header.
`include "refractive_index_dispersion_eval_core_defines.svh"

module ride_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] refractive_index,
  input logic [2:0]  status
);
  import ride_pkg::*;

  `RIDE_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `RIDE_ASSERT_NEXT(result_holds, out_valid && !out_ready, out_valid && $stable(refractive_index) && $stable(status), "stalled result changed")
  `RIDE_ASSERT_SAME(error_zero_index, out_valid && (status != ST_OK), refractive_index == 32'd0, "error result with nonzero index")
endmodule

bind refractive_index_dispersion_eval_core ride_checker u_ride_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for refractive_index_dispersion_eval_core.
// Depends on ride_pkg and the core; each result is checked against a built-in predictor or a directed-table value.
`timescale 1ns / 1ps

module tb_top;
  import ride_pkg::*;

  localparam logic [1:0] KIND_CONST = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic       ACT_EVAL   = 1'b1;
  localparam logic [63:0] Q52_ONE   = 64'h0010_0000_0000_0000;
  localparam int IDLE_LIMIT = 40000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic        action;
    logic [4:0]  slot;
    logic [31:0] strength;
    logic [39:0] resonance;
    logic [31:0] wl;
  } req_t;

  typedef struct packed {
    logic [31:0] index;
    status_t     st;
  } index_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_data;
    req_t        req;
    bit          typed;
    index_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [4:0] term_slot = '0;
  logic signed [31:0] term_strength = '0;
  logic [39:0] term_resonance = '0;
  logic [31:0] wavelength = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] refractive_index;
  logic [2:0] status;

  refractive_index_dispersion_eval_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .term_slot(term_slot),
    .term_strength(term_strength), .term_resonance(term_resonance), .wavelength(wavelength),
    .out_valid(out_valid), .out_ready(out_ready),
    .refractive_index(refractive_index), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [1:0]  m_kind;
  logic [31:0] m_a, m_b, m_c, m_dmin, m_dmax;
  logic [5:0]  m_count;
  logic [31:0] strength_mem [32];
  logic [39:0] resonance_mem [32];
  bit          slot_written [32];

  index_t index_q [$];
  int errors = 0;
  int items_in = 0;
  int results_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_MODEL_KIND: m_kind = data[1:0];
      REG_INDEX_A:    m_a = data;
      REG_CAUCHY_B:   m_b = data;
      REG_CAUCHY_C:   m_c = data;
      REG_DOMAIN_MIN: m_dmin = data;
      REG_DOMAIN_MAX: m_dmax = data;
      REG_TERM_COUNT: m_count = data[5:0];
      default: ;
    endcase
  endfunction

  function automatic bit mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                 output logic [63:0] q);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    q = '0;
    if (d == 0 || p[127:64] >= d) return 1'b0;
    p = p / {64'd0, d};
    q = p[63:0];
    return 1'b1;
  endfunction

  function automatic logic [31:0] int_sqrt(logic [63:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit coef_over_w2(longint coef, logic [63:0] w2, output longint o);
    logic [63:0] q;
    o = 0;
    if (!mul_div(magn(coef), Q52_ONE, w2, q) || q >= TERM_LIMIT) return 1'b0;
    o = coef < 0 ? -longint'(q) : longint'(q);
    return 1'b1;
  endfunction

  function automatic index_t eval_cauchy(logic [63:0] w2);
    index_t e;
    longint tb, t1, tc, s;
    e = '{index: '0, st: ST_OVERFLOW};
    if (!coef_over_w2(longint'($signed(m_b)), w2, tb)) return e;
    if (!coef_over_w2(longint'($signed(m_c)), w2, t1)) return e;
    if (!coef_over_w2(t1, w2, tc)) return e;
    s = longint'($signed(m_a)) + tb + tc;
    if (s <= 0) e.st = ST_NONPOS;
    else if (s > longint'(INDEX_MAX)) e.st = ST_OVERFLOW;
    else e = '{index: s[31:0], st: ST_OK};
    return e;
  endfunction

  function automatic index_t eval_sellmeier(logic [63:0] w2);
    index_t e;
    int n;
    longint s, b;
    logic [63:0] c, scale, den, tol, q;
    e = '{index: '0, st: ST_OK};
    n = m_count > 32 ? 32 : m_count;
    s = longint'(ONE_Q28);
    for (int k = 0; k < n; k++) begin
      c = {resonance_mem[k], 24'd0};
      scale = w2 > c ? w2 : c;
      den = w2 > c ? w2 - c : c - w2;
      b = longint'($signed(strength_mem[k]));
      void'(mul_div(64'd64, scale, Q52_ONE, tol));
      if (den <= tol) begin
        e.st = ST_POLE;
        return e;
      end
      if (!mul_div(magn(b), w2, den, q) || q >= TERM_LIMIT) begin
        e.st = ST_OVERFLOW;
        return e;
      end
      if ((b < 0) != (w2 < c)) s -= longint'(q);
      else s += longint'(q);
    end
    if (s <= 0) e.st = ST_NONPOS;
    else if (64'(s) >= SUM_LIMIT) e.st = ST_OVERFLOW;
    else e.index = int_sqrt(64'(s) << 28);
    return e;
  endfunction

  function automatic index_t predict_index(req_t r);
    index_t e;
    logic [63:0] w2;
    e = '{index: '0, st: ST_OK};
    if (r.action == ACT_WRITE) begin
      strength_mem[r.slot] = r.strength;
      resonance_mem[r.slot] = r.resonance;
      return e;
    end
    w2 = {32'd0, r.wl} * {32'd0, r.wl};
    if (r.wl == 0) e.st = ST_ZERO_WL;
    else if (r.wl < m_dmin || r.wl > m_dmax) e.st = ST_DOMAIN;
    else if (m_kind == KIND_CAUCHY) e = eval_cauchy(w2);
    else if (m_kind == KIND_SELLMEIER) e = eval_sellmeier(w2);
    else if ($signed(m_a) <= 0) e.st = ST_NONPOS;
    else e.index = m_a;
    return e;
  endfunction

  function automatic logic [31:0] rand_wl();
    int p;
    p = $urandom_range(99);
    if (p < 4) return 32'd0;
    if (p < 14) return $urandom;
    if (p < 20) return m_dmin + $urandom_range(2) - 1;
    if (p < 26) return m_dmax + $urandom_range(2) - 1;
    return $urandom_range(32'd335544320, 32'd13421772);
  endfunction

  function automatic req_t make_req();
    req_t r;
    int n;
    int miss;
    r.action = ACT_EVAL;
    r.slot = 5'($urandom);
    r.strength = $urandom;
    r.resonance = {8'($urandom), 32'($urandom)};
    r.wl = rand_wl();
    n = m_count > 32 ? 32 : m_count;
    miss = -1;
    if (m_kind == KIND_SELLMEIER)
      for (int k = n - 1; k >= 0; k--) if (!slot_written[k]) miss = k;
    if (miss >= 0 || $urandom_range(99) < 25) begin
      r.action = ACT_WRITE;
      if (miss >= 0) r.slot = miss[4:0];
      if ($urandom_range(9) < 8) begin
        r.strength = $urandom_range(32'd402653184, 32'd0);
        if ($urandom_range(9) == 0) r.strength = -r.strength;
        r.resonance = 40'($urandom_range(($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                                                   : 32'd53687091));
      end
      slot_written[r.slot] = 1'b1;
    end else if (m_kind == KIND_SELLMEIER && n > 0 && $urandom_range(9) == 0) begin
      r.wl = int_sqrt({resonance_mem[$urandom_range(n - 1)], 24'd0}) + $urandom_range(2) - 1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic wait_drained();
    wait (index_q.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_req(req_t r, bit typed, index_t want);
    index_t e;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(8);
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= r.action;
    term_slot <= r.slot;
    term_strength <= r.strength;
    term_resonance <= r.resonance;
    wavelength <= r.wl;
    do @(posedge clk); while (!in_ready);
    e = predict_index(r);
    index_q.push_back(typed ? want : e);
    items_in++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] data);
    row_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.reg_idx = idx;
    w.reg_data = data;
    return w;
  endfunction

  function automatic row_t req_row(logic act, logic [4:0] sl, logic [31:0] b, logic [39:0] c,
                                   logic [31:0] wl, bit typed, logic [31:0] idx, status_t st);
    row_t w;
    w = '{default: '0};
    w.req = '{action: act, slot: sl, strength: b, resonance: c, wl: wl};
    w.typed = typed;
    w.want = '{index: idx, st: st};
    return w;
  endfunction

  row_t rows [$];

  always @(posedge clk) begin
    index_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (index_q.size() == 0) begin
        $error("result with nothing expected: index %h status %0d", refractive_index, status);
        errors++;
      end else begin
        e = index_q.pop_front();
        if (refractive_index !== e.index) begin
          $error("refractive_index expected %h actual %h", e.index, refractive_index);
          errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int hold;
    int mode;
    wait (!rst);
    mode = 0;
    forever begin
      @(negedge clk);
      if (results_seen >= 60 && mode == 0) begin
        mode = 1;
        out_ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clk);
      end
      case (($urandom_range(0, 199) + results_seen) % 4)
        0: out_ready <= 1'b0;
        1: out_ready <= $urandom_range(3) != 0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  initial begin
    m_kind = KIND_CONST;
    m_a = 32'h1000_0000;
    m_b = '0;
    m_c = '0;
    m_dmin = 32'd1;
    m_dmax = 32'hFFFF_FFFF;
    m_count = 6'd1;
    foreach (slot_written[k]) begin
      slot_written[k] = 1'b0;
      strength_mem[k] = '0;
      resonance_mem[k] = '0;
    end

    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'd0, 1, 32'd0, ST_ZERO_WL));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'd1, 1, 32'h1000_0000, ST_OK));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'h1000_0000, ST_OK));
    rows.push_back(req_row(ACT_WRITE, 31, 32'h8000_0000, 40'hFF_FFFF_FFFF, 0, 1, 0, ST_OK));
    rows.push_back(req_row(ACT_WRITE, 0, 32'h1000_0000, 40'h04000000, 32'hFFFF_FFFF,
                           1, 0, ST_OK));
    rows.push_back(req_row(ACT_WRITE, 1, 32'h7FFF_FFFF, 40'd0, 0, 1, 0, ST_OK));
    rows.push_back(cfg_row(REG_MODEL_KIND, {30'd0, KIND_SPARE}));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 1, 32'h1000_0000, ST_OK));
    rows.push_back(cfg_row(REG_INDEX_A, 32'd0));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 1, 32'd0, ST_NONPOS));
    rows.push_back(cfg_row(REG_INDEX_A, 32'h8000_0000));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 1, 32'd0, ST_NONPOS));
    rows.push_back(cfg_row(REG_INDEX_A, 32'h7FFF_FFFF));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 1, 32'h7FFF_FFFF, ST_OK));
    rows.push_back(cfg_row(REG_DOMAIN_MIN, 32'd100));
    rows.push_back(cfg_row(REG_DOMAIN_MAX, 32'd50));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'd75, 1, 32'd0, ST_DOMAIN));
    rows.push_back(cfg_row(REG_DOMAIN_MIN, 32'd1));
    rows.push_back(cfg_row(REG_DOMAIN_MAX, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_MODEL_KIND, {30'd0, KIND_CAUCHY}));
    rows.push_back(cfg_row(REG_INDEX_A, 32'h1800_0000));
    rows.push_back(cfg_row(REG_CAUCHY_B, 32'h0040_0000));
    rows.push_back(cfg_row(REG_CAUCHY_C, 32'h0001_0000));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0200_0000, 0, 0, ST_OK));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'd1, 1, 32'd0, ST_OVERFLOW));
    rows.push_back(cfg_row(REG_CAUCHY_B, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_CAUCHY_C, 32'h8000_0000));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 0, 0, ST_OK));
    rows.push_back(cfg_row(REG_MODEL_KIND, {30'd0, KIND_SELLMEIER}));
    rows.push_back(cfg_row(REG_TERM_COUNT, 32'd0));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 1, 32'h1000_0000, ST_OK));
    rows.push_back(cfg_row(REG_TERM_COUNT, 32'd2));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0200_0000, 1, 32'd0, ST_POLE));
    rows.push_back(req_row(ACT_EVAL, 0, 0, 0, 32'h0400_0000, 0, 0, ST_OK));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        stop_sending();
        wait_drained();
        write_reg(rows[k].reg_idx, rows[k].reg_data);
        @(negedge clk);
        cfg_valid <= 1'b0;
      end else begin
        if (rows[k].req.action == ACT_WRITE) slot_written[rows[k].req.slot] = 1'b1;
        send_req(rows[k].req, rows[k].typed, rows[k].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      stop_sending();
      wait_drained();
      case (ph)
        0, 4: write_reg(REG_MODEL_KIND, {30'd0, KIND_SELLMEIER});
        1, 5: write_reg(REG_MODEL_KIND, {30'd0, KIND_CAUCHY});
        2:    write_reg(REG_MODEL_KIND, {30'd0, KIND_CONST});
        default: write_reg(REG_MODEL_KIND, {30'd0, KIND_SELLMEIER});
      endcase
      write_reg(REG_INDEX_A, ph == 2 ? $urandom : $urandom_range(32'h2000_0000, 32'h1000_0000));
      write_reg(REG_CAUCHY_B, ph == 5 ? $urandom : $urandom_range(32'h0100_0000));
      write_reg(REG_CAUCHY_C, ph == 5 ? $urandom : $urandom_range(32'h0010_0000));
      write_reg(REG_DOMAIN_MIN, ph == 6 ? 32'd0 : $urandom_range(32'h0100_0000));
      write_reg(REG_DOMAIN_MAX, ph == 6 ? 32'hFFFF_FFFF : $urandom_range(32'hF000_0000,
                                                                        32'h1000_0000));
      case (ph)
        3: write_reg(REG_TERM_COUNT, 32'd32);
        7: write_reg(REG_TERM_COUNT, 32'd63);
        default: write_reg(REG_TERM_COUNT, $urandom_range(4, 1));
      endcase
      @(negedge clk);
      cfg_valid <= 1'b0;
      repeat (ph == 3 || ph == 7 ? 30 : 50) send_req(make_req(), 1'b0, '0);
    end

    stop_sending();
    wait (index_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d transactions across constant, Cauchy and Sellmeier models,", items_in);
    $display("with term writes, domain, pole, overflow and back-pressure cases.");
    if (errors == 0 && index_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ride_pkg.sv
design/ride_divider.sv
design/ride_sqrt.sv
design/refractive_index_dispersion_eval_core.sv
design/ride_checker.sv
sim/tb_top.sv
